FILE: hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, function codes, ring index helpers and the control struct
// of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 11;
   localparam int WORD_W = 32;
   localparam int FUNC_W = 3;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_PEEK       = 3'd4
   } func_type;

   // decision for one request, taken from the current queue state
   typedef struct packed {
      logic             ok;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] front_addr;
      logic [IDX_W-1:0] rear_addr;
      logic [CNT_W-1:0] count;
      logic             full;
   } step_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

endpackage

FILE: hdl/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_if
// Request and response channels of the bounded double-ended queue.
// ----------------------------------------------------------------------------
interface bdq_req_if;
   logic                             valid;
   logic                             ready;
   logic [bdq_pkg::FUNC_W-1:0]       func;
   logic signed [bdq_pkg::WORD_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              success;
   logic signed [bdq_pkg::WORD_W-1:0] front_value;
   logic signed [bdq_pkg::WORD_W-1:0] rear_value;
   logic                              is_empty;
   logic                              is_full;
   logic [bdq_pkg::CNT_W-1:0]         occupancy;

   modport source (output valid, output success, output front_value, output rear_value,
                   output is_empty, output is_full, output occupancy, input ready);
   modport sink   (input valid, input success, input front_value, input rear_value,
                   input is_empty, input is_full, input occupancy, output ready);
endinterface

FILE: hdl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit words kept in a ring buffer with head and
// tail indices; one request in, one response out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries a request word: func (push front, push back, pop front,
//   pop back, peek) and the value to push. rsp_ch returns one word per
//   request: success, front and rear words (-1 when empty), empty and full
//   flags and occupancy after the request.
//   csr_wr_en/csr_wr_data set the capacity; write it only while idle.
//   Throughput: one request per cycle while the receiver does not stall;
//   the request register feeds the index logic and the ring RAM, whose
//   registered read ports form the response register.
//   Reset empties the queue and sets the capacity to 1024; slot contents are
//   not cleared since only written slots are ever read.
//   When the receiver stalls, the response holds and one more request is
//   taken into the request register; then req_ch.ready drops.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
   input  logic                       clock,
   input  logic                       reset,
   bdq_req_if.sink                    req_ch,
   bdq_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [bdq_pkg::CNT_W-1:0]  csr_wr_data
);
   import bdq_pkg::*;

   logic                     capacity_ff;
   logic [CNT_W-1:0]         cap_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0]        in_func_ff;
   logic [WORD_W-1:0]        in_value_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     success_ff;
   logic                     empty_ff;
   logic                     full_ff;
   logic [CNT_W-1:0]         occupancy_ff;
   logic [WORD_W-1:0]        front_rd_ff;
   logic [WORD_W-1:0]        rear_rd_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     req_fire;
   logic                     advance;
   step_type                 step;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // marks that the capacity has been written since reset (status only)
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 1'b0;
      end else if (csr_wr_en) begin
         capacity_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff  <= req_ch.func;
         in_value_ff <= req_ch.value;
      end
   end

   bdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .func     (in_func_ff),
      .capacity (cap_ff),
      .step     (step),
      .count_ff (count_ff)
   );

   bdq_ram #(
      .WORDS  (DEPTH),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock        (clock),
      .wr_en        (advance && step.wr_en),
      .wr_addr      (step.wr_addr),
      .wr_data      (in_value_ff),
      .rd_en        (advance),
      .rd_addr_a    (step.front_addr),
      .rd_addr_b    (step.rear_addr),
      .rd_data_a_ff (front_rd_ff),
      .rd_data_b_ff (rear_rd_ff)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         success_ff   <= step.ok;
         empty_ff     <= step.count == '0;
         full_ff      <= step.full;
         occupancy_ff <= step.count;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.success     = success_ff;
   assign rsp_ch.front_value = empty_ff ? '1 : $signed(front_rd_ff);
   assign rsp_ch.rear_value  = empty_ff ? '1 : $signed(rear_rd_ff);
   assign rsp_ch.is_empty    = empty_ff;
   assign rsp_ch.is_full     = full_ff;
   assign rsp_ch.occupancy   = occupancy_ff;

   // a refused request must leave the occupancy as it was
   assert property (@(posedge clock) disable iff (reset)
      (advance && !step.ok) |=> count_ff == $past(count_ff))
      else $error("refused request changed the occupancy");

   // occupancy never goes past the ring size (a capacity that was not lowered bounds it too)
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("occupancy beyond ring size");

   // a reported occupancy of zero goes with the empty flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (occupancy_ff == '0)))
      else $error("empty flag disagrees with occupancy");

   // until the capacity is first written after reset, the full flag follows the ring size
   assert property (@(posedge clock) disable iff (reset)
      (advance && !capacity_ff) |-> (step.full == (step.count >= DEPTH_CNT)))
      else $error("full flag wrong at reset capacity");

endmodule

FILE: hdl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM, one write port and two registered read ports; a read of the
// address written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WORDS  = 1024,
   parameter int DATA_W = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(WORDS)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(WORDS)-1:0]   rd_addr_a,
   input  logic [$clog2(WORDS)-1:0]   rd_addr_b,
   output logic [DATA_W-1:0]          rd_data_a_ff,
   output logic [DATA_W-1:0]          rd_data_b_ff
);

   logic [DATA_W-1:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         rd_data_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

endmodule

FILE: hdl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head, tail and count registers of the ring; decides whether a request is
// carried out and which slots it writes and reads.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [bdq_pkg::FUNC_W-1:0] func,
   input  logic [bdq_pkg::CNT_W-1:0]  capacity,
   output bdq_pkg::step_type          step,
   output logic [bdq_pkg::CNT_W-1:0]  count_ff
);
   import bdq_pkg::*;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] cap_eff;
   logic             has_room;
   logic             has_entry;

   assign cap_eff   = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
   assign has_room  = count_ff < cap_eff;
   assign has_entry = count_ff != '0;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      step.ok      = 1'b1;
      step.wr_en   = 1'b0;
      step.wr_addr = tail_ff;
      case (func)
         FUNC_PUSH_FRONT: begin
            step.ok = has_room;
            if (has_room) begin
               head_in      = ring_prev(head_ff);
               step.wr_en   = 1'b1;
               step.wr_addr = ring_prev(head_ff);
               count_in     = count_ff + 1'b1;
            end
         end
         FUNC_PUSH_BACK: begin
            step.ok = has_room;
            if (has_room) begin
               tail_in    = ring_next(tail_ff);
               step.wr_en = 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         FUNC_POP_FRONT: begin
            step.ok = has_entry;
            if (has_entry) begin
               head_in  = ring_next(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         FUNC_POP_BACK: begin
            step.ok = has_entry;
            if (has_entry) begin
               tail_in  = ring_prev(tail_ff);
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            // peek and unused codes leave the ring alone
         end
      endcase
      step.front_addr = head_in;
      step.rear_addr  = ring_prev(tail_in);
      step.count      = count_in;
      step.full       = count_in >= cap_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: tb/sv/bounded_double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Self-checking bench for the bounded deque. A shadow ring in a small
// scoreboard class predicts every response word from the accepted requests.
// A short directed run covers empty and full edges, the extreme words,
// every function code and capacity changes. Random phases then sweep the
// capacity, both flow directions through the ring and the handshake stalls.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;
   import bdq_pkg::*;

   // bounds the slowest run, near 900 words under idles and stalls, plus hold-offs
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 40;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -1;
   localparam logic signed [WORD_W-1:0] WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
   // spare codes above peek behave as peek
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_CODE_LAST   = 3'd7;

   typedef enum int {FLOW_MIXED, FLOW_BACK_IN, FLOW_FRONT_IN} flow_kind_type;

   typedef struct packed {
      logic                     success;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
      logic [CNT_W-1:0]         occupancy;
   } deque_view_type;

   class deque_shadow;
      logic signed [WORD_W-1:0] slots [DEPTH];
      logic [IDX_W-1:0]         head;
      logic [IDX_W-1:0]         tail;
      logic [CNT_W-1:0]         held;
      logic [CNT_W-1:0]         capacity;
      deque_view_type           awaited [$];
      int                       errors;

      function new();
         head     = '0;
         tail     = '0;
         held     = '0;
         capacity = CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(input logic [CNT_W-1:0] c);
         capacity = c;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // ring indices wrap by their own width since the depth is a power of two
      function void take_request(input logic [FUNC_W-1:0] f,
                                 input logic signed [WORD_W-1:0] v);
         logic [CNT_W-1:0] limit;
         logic [IDX_W-1:0] rear_idx;
         deque_view_type   view;
         limit        = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
         view.success = 1'b1;
         case (f)
            FUNC_PUSH_FRONT: begin
               if (held >= limit) begin
                  view.success = 1'b0;
               end else begin
                  head        = head - 1'b1;
                  slots[head] = v;
                  held        = held + 1'b1;
               end
            end
            FUNC_PUSH_BACK: begin
               if (held >= limit) begin
                  view.success = 1'b0;
               end else begin
                  slots[tail] = v;
                  tail        = tail + 1'b1;
                  held        = held + 1'b1;
               end
            end
            FUNC_POP_FRONT: begin
               if (held == '0) begin
                  view.success = 1'b0;
               end else begin
                  head = head + 1'b1;
                  held = held - 1'b1;
               end
            end
            FUNC_POP_BACK: begin
               if (held == '0) begin
                  view.success = 1'b0;
               end else begin
                  tail = tail - 1'b1;
                  held = held - 1'b1;
               end
            end
            default: begin
            end
         endcase
         rear_idx         = tail - 1'b1;
         view.is_empty    = (held == '0);
         view.is_full     = (held >= limit);
         view.occupancy   = held;
         view.front_value = view.is_empty ? EMPTY_WORD : slots[head];
         view.rear_value  = view.is_empty ? EMPTY_WORD : slots[rear_idx];
         awaited.push_back(view);
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endtask

      task match_response(input deque_view_type got);
         deque_view_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("response word with no request outstanding, occupancy %0d",
                                      got.occupancy));
            return;
         end
         want = awaited.pop_front();
         if (got.success !== want.success)
            report_mismatch($sformatf("success %b, want %b", got.success, want.success));
         if (got.front_value !== want.front_value)
            report_mismatch($sformatf("front_value %0d, want %0d",
                                      got.front_value, want.front_value));
         if (got.rear_value !== want.rear_value)
            report_mismatch($sformatf("rear_value %0d, want %0d",
                                      got.rear_value, want.rear_value));
         if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
         if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full %b, want %b", got.is_full, want.is_full));
         if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   deque_shadow    shadow = new();
   deque_view_type observed;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   bit             hold_off_pending = 1'b0;

   bounded_double_ended_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_double_ended_queue_tb: FAIL");
         $finish;
      end
   end

   // request noted before response on the same edge
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         shadow.take_request(req_bus.func, req_bus.value);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.success     = rsp_bus.success;
         observed.front_value = rsp_bus.front_value;
         observed.rear_value  = rsp_bus.rear_value;
         observed.is_empty    = rsp_bus.is_empty;
         observed.is_full     = rsp_bus.is_full;
         observed.occupancy   = rsp_bus.occupancy;
         shadow.match_response(observed);
      end
   end

   // receiver: random stalls, or a long hold-off counted here
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            for (int k = 0; k < HOLD_OFF_CYCLES; k++) begin
               rsp_bus.ready = 1'b0;
               @(negedge clock);
            end
         end
         rsp_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] f, input logic signed [WORD_W-1:0] v);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.func  = f;
      req_bus.value = v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] c);
      while (shadow.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = c;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      shadow.set_capacity(c);
   endtask

   task automatic run_random(input int count, input int push_pct, input int pop_pct,
                             input flow_kind_type flow);
      logic [FUNC_W-1:0]        f;
      logic signed [WORD_W-1:0] v;
      int                       r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < push_pct) begin
            if (flow == FLOW_BACK_IN)       f = FUNC_PUSH_BACK;
            else if (flow == FLOW_FRONT_IN) f = FUNC_PUSH_FRONT;
            else f = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
         end else if (r < push_pct + pop_pct) begin
            if (flow == FLOW_BACK_IN)       f = FUNC_POP_FRONT;
            else if (flow == FLOW_FRONT_IN) f = FUNC_POP_BACK;
            else f = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
         end else begin
            f = FUNC_W'($urandom_range(FUNC_PEEK, FUNC_CODE_LAST));
         end
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0:       v = WORD_MIN;
               1:       v = WORD_MAX;
               2:       v = '0;
               default: v = EMPTY_WORD;
            endcase
         end else begin
            v = $urandom();
         end
         send_request(f, v);
      end
      end_burst();
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.func  = FUNC_PEEK;
      req_bus.value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue at reset capacity, extreme words, every code
      send_request(FUNC_PEEK, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_BACK, '0);
      send_request(FUNC_PUSH_FRONT, WORD_MIN);
      send_request(FUNC_PUSH_BACK, WORD_MAX);
      send_request(FUNC_PUSH_FRONT, '0);
      send_request(FUNC_PUSH_BACK, EMPTY_WORD);
      for (int f = FUNC_SPARE_FIRST; f <= FUNC_CODE_LAST; f++) begin
         send_request(FUNC_W'(f), $urandom());
      end
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_BACK, '0);
      end_burst();

      // zero capacity below occupancy, then empty and full at once
      write_capacity('0);
      send_request(FUNC_PUSH_FRONT, $urandom());
      send_request(FUNC_POP_BACK, '0);
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_PUSH_BACK, $urandom());
      end_burst();

      // fill a small capacity, then lower it under the occupancy
      write_capacity(CNT_W'(3));
      repeat (3) send_request(FUNC_PUSH_BACK, $urandom());
      end_burst();
      write_capacity(CNT_W'(1));
      send_request(FUNC_PUSH_FRONT, $urandom());
      send_request(FUNC_POP_FRONT, '0);
      send_request(FUNC_POP_BACK, '0);
      end_burst();

      send_idle_pct  = 35;
      recv_stall_pct = 85;
      write_capacity('1);
      hold_off_pending = 1'b1;
      run_random(150, 60, 30, FLOW_FRONT_IN);
      write_capacity(CNT_W'(5));
      run_random(120, 35, 55, FLOW_MIXED);

      send_idle_pct  = 85;
      recv_stall_pct = 35;
      write_capacity(CNT_W'(1));
      run_random(100, 45, 45, FLOW_MIXED);
      write_capacity(CNT_W'(1025));
      run_random(160, 55, 40, FLOW_BACK_IN);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_capacity(CNT_W'(16));
      hold_off_pending = 1'b1;
      run_random(160, 45, 50, FLOW_FRONT_IN);
      write_capacity('0);
      run_random(20, 50, 40, FLOW_MIXED);
      write_capacity(CNT_W'($urandom_range(2, 40)));
      run_random(120, 50, 45, FLOW_MIXED);

      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("bounded_double_ended_queue_tb: PASS");
      end else begin
         $display("bounded_double_ended_queue_tb: FAIL");
      end
      $finish;
   end

endmodule
